/* design/assert_macros.svh */
// Assertion helpers for the job queue checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every edge out of reset
`define TLQ_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("tlq check failed");

// check at every edge, reset included
`define TLQ_ASSERT_ALWAYS(lbl, clk, expr) \
  lbl: assert property (@(posedge clk) (expr)) else $error("tlq check failed");

`endif

/* design/tlq_pkg.sv */
package tlq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS = 16;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_INS = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_CAN = 2'd2,
    ACT_NOP = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT
  } bk_state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
  } job_t;

  typedef struct packed {
    act_t        act;
    logic [15:0] id;
    logic [15:0] pages;
    logic        prio;
  } cmd_t;
endpackage

/* design/tlq_front.sv */
module tlq_front import tlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_pages,
  input  logic        in_is_priority,
  output logic        cmd_v,
  output cmd_t        cmd,
  input  logic        cmd_pop
);
  localparam int FC = $clog2(CMD_DEPTH + 1);
  localparam int FW = $clog2(CMD_DEPTH);
  cmd_t          e_r [CMD_DEPTH];
  cmd_t          e_nxt [CMD_DEPTH];
  logic [FC-1:0] cnt_r, cnt_nxt;
  cmd_t          inc;
  logic          wr, rd;

  always_comb begin
    inc.act   = act_t'(in_action);
    inc.id    = in_job_id & 16'((64'd1 << ID_BITS) - 64'd1);
    inc.pages = in_pages;
    inc.prio  = in_is_priority;
  end

  assign full  = (cnt_r == FC'(CMD_DEPTH));
  assign cmd_v = (cnt_r != '0);
  assign cmd   = e_r[0];
  assign wr    = push && !full;
  assign rd    = cmd_pop && cmd_v;

  always_comb begin
    e_nxt = e_r;
    cnt_nxt = cnt_r;
    if (rd) begin
      for (int i = 0; i < CMD_DEPTH - 1; i++) e_nxt[i] = e_r[i + 1];
    end
    if (wr) e_nxt[FW'(cnt_r - FC'(rd))] = inc;
    cnt_nxt = cnt_r + FC'(wr) - FC'(rd);
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end
endmodule

/* design/tlq_back.sv */
module tlq_back import tlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_v,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_job_id,
  output logic [15:0] out_pages,
  output logic        out_from_priority,
  output logic [4:0]  out_priority_count,
  output logic [4:0]  out_normal_count
);
  job_t pmem [QUEUE_DEPTH];
  job_t nmem [QUEUE_DEPTH];
  job_t prd_r, nrd_r, rsel;

  bk_state_t     st_r, st_nxt;
  cmd_t          cur_r, cur_nxt;
  logic          q_r, q_nxt;
  logic [CW-1:0] idx_r, idx_nxt, pcnt_r, pcnt_nxt, ncnt_r, ncnt_nxt, cnt_q, cnt_ins;
  logic          cv_r, cv_nxt, wv_r, wv_nxt;
  logic [IW-1:0] cpos_r, cpos_nxt, wpos_r, wpos_nxt, raddr, waddr;
  job_t          rem_r, rem_nxt, wdata;
  logic          we, wq, done, hit;
  status_t       dst;
  job_t          djob;
  logic          dfrom;

  logic          ov_r, ov_nxt;
  status_t       rs_r, rs_nxt;
  job_t          rj_r, rj_nxt;
  logic          rf_r, rf_nxt;
  logic [CW-1:0] rpc_r, rpc_nxt, rnc_r, rnc_nxt;

  assign rsel    = q_r ? prd_r : nrd_r;
  assign cnt_q   = q_r ? pcnt_r : ncnt_r;
  assign cnt_ins = cur_r.prio ? pcnt_r : ncnt_r;
  assign raddr   = idx_r[IW-1:0];
  assign hit     = cv_r && (cur_r.act == ACT_DEQ || rsel.id == cur_r.id);

  always_comb begin
    st_nxt = st_r;  cur_nxt = cur_r;  q_nxt = q_r;  idx_nxt = idx_r;
    cv_nxt = cv_r;  cpos_nxt = cpos_r;  wv_nxt = wv_r;  wpos_nxt = wpos_r;
    rem_nxt = rem_r;  pcnt_nxt = pcnt_r;  ncnt_nxt = ncnt_r;
    cmd_pop = 1'b0;  we = 1'b0;  wq = q_r;  waddr = wpos_r;  wdata = rsel;
    done = 1'b0;  dst = ST_OK;  djob = '0;  dfrom = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (cmd_v && !ov_r) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          idx_nxt = '0;
          cv_nxt  = 1'b0;
          case (cmd.act)
            ACT_INS: begin
              q_nxt = 1'b0;
              st_nxt = BK_SCAN;
            end
            ACT_DEQ: begin
              if (pcnt_r != '0) begin
                q_nxt = 1'b1;
                st_nxt = BK_SCAN;
              end else if (ncnt_r != '0) begin
                q_nxt = 1'b0;
                st_nxt = BK_SCAN;
              end else begin
                done = 1'b1;
                dst = ST_EMPTY;
              end
            end
            ACT_CAN: begin
              q_nxt = 1'b1;
              st_nxt = BK_SCAN;
            end
            default: done = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        if (idx_r < cnt_q) begin
          idx_nxt = idx_r + CW'(1);
          cv_nxt = 1'b1;
          cpos_nxt = idx_r[IW-1:0];
        end else begin
          cv_nxt = 1'b0;
        end
        if (hit) begin
          if (cur_r.act == ACT_INS) begin
            done = 1'b1;
            dst = ST_DUP;
            st_nxt = BK_IDLE;
          end else begin
            rem_nxt = rsel;
            idx_nxt = CW'(cpos_r) + CW'(1);
            wv_nxt = 1'b0;
            st_nxt = BK_SHIFT;
          end
        end else if (!cv_r && idx_r >= cnt_q) begin
          if (cur_r.act == ACT_INS) begin
            if (!q_r) begin
              q_nxt = 1'b1;
              idx_nxt = '0;
              cv_nxt = 1'b0;
            end else begin
              st_nxt = BK_IDLE;
              done = 1'b1;
              if (cnt_ins >= CW'(QUEUE_DEPTH)) begin
                dst = ST_FULL;
              end else begin
                we = 1'b1;
                wq = cur_r.prio;
                waddr = cnt_ins[IW-1:0];
                wdata.id = cur_r.id;
                wdata.pages = cur_r.pages;
                if (cur_r.prio) pcnt_nxt = pcnt_r + CW'(1);
                else ncnt_nxt = ncnt_r + CW'(1);
              end
            end
          end else if (q_r) begin
            q_nxt = 1'b0;
            idx_nxt = '0;
            cv_nxt = 1'b0;
          end else begin
            st_nxt = BK_IDLE;
            done = 1'b1;
            dst = ST_NOTFOUND;
          end
        end
      end
      BK_SHIFT: begin
        if (idx_r < cnt_q) begin
          idx_nxt = idx_r + CW'(1);
          wv_nxt = 1'b1;
          wpos_nxt = idx_r[IW-1:0] - IW'(1);
        end else begin
          wv_nxt = 1'b0;
        end
        if (wv_r) we = 1'b1;
        if (!wv_r && idx_r >= cnt_q) begin
          if (q_r) pcnt_nxt = pcnt_r - CW'(1);
          else ncnt_nxt = ncnt_r - CW'(1);
          done = 1'b1;
          djob = rem_r;
          dfrom = q_r;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && !pop;
    rs_nxt = rs_r;  rj_nxt = rj_r;  rf_nxt = rf_r;  rpc_nxt = rpc_r;  rnc_nxt = rnc_r;
    if (done) begin
      ov_nxt = 1'b1;
      rs_nxt = dst;
      rj_nxt = djob;
      rf_nxt = dfrom;
      rpc_nxt = pcnt_nxt;
      rnc_nxt = ncnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prd_r <= pmem[raddr];
    nrd_r <= nmem[raddr];
    if (we && wq) pmem[waddr] <= wdata;
    if (we && !wq) nmem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;  q_r <= q_nxt;  idx_r <= idx_nxt;  cpos_r <= cpos_nxt;
    wpos_r <= wpos_nxt;  rem_r <= rem_nxt;
    rs_r <= rs_nxt;  rj_r <= rj_nxt;  rf_r <= rf_nxt;  rpc_r <= rpc_nxt;  rnc_r <= rnc_nxt;
    if (!rst_n) begin
      st_r <= BK_IDLE;
      cv_r <= 1'b0;
      wv_r <= 1'b0;
      pcnt_r <= '0;
      ncnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cv_r <= cv_nxt;
      wv_r <= wv_nxt;
      pcnt_r <= pcnt_nxt;
      ncnt_r <= ncnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign empty              = !ov_r;
  assign out_status         = rs_r;
  assign out_job_id         = rj_r.id;
  assign out_pages          = rj_r.pages;
  assign out_from_priority  = rf_r;
  assign out_priority_count = 5'(rpc_r);
  assign out_normal_count   = 5'(rnc_r);
endmodule

/* design/two_level_job_queue_with_cancel_core.sv */
// channel   handshake       payload
// input     push / full     in_action in_job_id in_pages in_is_priority
// result    pop / empty     out_status out_job_id out_pages out_from_priority
//                           out_priority_count out_normal_count
// A two-entry command queue takes items while the back end works.
// A scan reads a queue's jobs in order; insert scans both queues.
// Cancel scans up to the hit, then closes the gap by moving each job behind it forward.
// Dequeue removes the head of the priority queue, or of the normal queue if that is empty.
// Synchronous reset empties both queues; a held result stalls the back end only.
module two_level_job_queue_with_cancel_core import tlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_pages,
  input  logic        in_is_priority,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_job_id,
  output logic [15:0] out_pages,
  output logic        out_from_priority,
  output logic [4:0]  out_priority_count,
  output logic [4:0]  out_normal_count
);
  logic cmd_v, cmd_pop;
  cmd_t cmd;

  tlq_front u_front (
    .clk, .rst_n, .push, .full, .in_action, .in_job_id, .in_pages, .in_is_priority,
    .cmd_v, .cmd, .cmd_pop
  );

  tlq_back u_back (
    .clk, .rst_n, .cmd_v, .cmd, .cmd_pop, .empty, .pop, .out_status, .out_job_id,
    .out_pages, .out_from_priority, .out_priority_count, .out_normal_count
  );
endmodule

/* design/tlq_checker.sv */
`include "assert_macros.svh"
module tlq_checker import tlq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_status,
  input logic [15:0] out_job_id,
  input logic        out_from_priority,
  input logic [4:0]  out_priority_count,
  input logic [4:0]  out_normal_count
);
  `TLQ_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_job_id)))
  `TLQ_ASSERT(a_counts, clk, rst_n, !empty |-> (out_priority_count <= 5'(QUEUE_DEPTH) && out_normal_count <= 5'(QUEUE_DEPTH)))
  `TLQ_ASSERT(a_fail_zero, clk, rst_n, (!empty && out_status != ST_OK) |-> (out_job_id == '0 && !out_from_priority))
  `TLQ_ASSERT(a_empty_st, clk, rst_n, (!empty && out_status == ST_EMPTY) |-> (out_priority_count == '0 && out_normal_count == '0))
  `TLQ_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> empty)
endmodule

bind two_level_job_queue_with_cancel_core tlq_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_status, .out_job_id, .out_from_priority,
  .out_priority_count, .out_normal_count
);
